// File: rtl/scan_disk_scheduler_macros.svh
// ---------------------------------------------------------------------------
// scan_disk_scheduler_macros.svh
// assertion macros shared by the scheduler checks
// ---------------------------------------------------------------------------
`ifndef SCAN_DISK_SCHEDULER_MACROS_SVH
`define SCAN_DISK_SCHEDULER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SDS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scan_disk_scheduler check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SDS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scan_disk_scheduler check failed");

`endif

// File: rtl/sds_pkg.sv
// ---------------------------------------------------------------------------
// sds_pkg
// shared widths, constants and types of the scan disk scheduler
// ---------------------------------------------------------------------------
package sds_pkg;

	// cylinder numbers are this wide
	localparam int unsigned CYL_W            = 16;
	// disk size register and running total
	localparam int unsigned SIZE_W           = 17;
	localparam int unsigned TOTAL_W          = 17;
	localparam int unsigned MAX_REQUESTS_DEF = 32;

	localparam logic [SIZE_W-1:0] DISK_SIZE_RESET = SIZE_W'(200);
	localparam logic [SIZE_W-1:0] SIZE_MIN        = SIZE_W'(2);
	localparam logic [SIZE_W-1:0] SIZE_MAX        = SIZE_W'(1) << CYL_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_PICK = 3'b100
	} state_t;

	// per-cycle control of the compare unit
	typedef struct packed {
		logic clear;
		logic sample;
		logic served;
		logic phase_b;
		logic dir_up;
	} scan_ctl_t;

endpackage

// File: rtl/sds_store.sv
// ---------------------------------------------------------------------------
// sds_store
// request memory, one write port and one registered read port
// ---------------------------------------------------------------------------
module sds_store #(
	parameter int unsigned DEPTH = sds_pkg::MAX_REQUESTS_DEF,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  logic [sds_pkg::CYL_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [ADDR_W-1:0]        rd_addr,
	output logic [sds_pkg::CYL_W-1:0] rd_data
);
	import sds_pkg::*;

	logic [CYL_W-1:0] mem_q [DEPTH];
	logic [CYL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/sds_scan.sv
// ---------------------------------------------------------------------------
// sds_scan
// shared compare unit: tracks the best unserved request over one pass
// ---------------------------------------------------------------------------
module sds_scan #(
	parameter int unsigned DEPTH = sds_pkg::MAX_REQUESTS_DEF,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sds_pkg::scan_ctl_t        ctl,
	input  logic [ADDR_W-1:0]         idx,
	input  logic [sds_pkg::CYL_W-1:0] data,
	input  logic [sds_pkg::CYL_W-1:0] start,
	output logic                      found,
	output logic [sds_pkg::CYL_W-1:0] best,
	output logic [ADDR_W-1:0]         best_idx
);
	import sds_pkg::*;

	logic             found_q;
	logic [CYL_W-1:0] best_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic             on_side;
	logic             want_min;
	logic             better;
	logic             take;

	// first pass keeps to the head's side, second pass takes whatever is left
	assign on_side  = ctl.dir_up ? (data >= start) : (data <= start);
	assign want_min = ctl.dir_up ^ ctl.phase_b;
	assign better   = !found_q || (want_min ? (data < best_q) : (data > best_q));
	assign take     = ctl.sample && !ctl.served && (ctl.phase_b || on_side) && better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !ctl.clear) begin
			best_q     <= data;
			best_idx_q <= idx;
		end
	end

	assign found    = found_q;
	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

// File: rtl/scan_disk_scheduler.sv
// ---------------------------------------------------------------------------
// scan_disk_scheduler
// scan (elevator) disk scheduler over a stored batch of cylinder requests
// ---------------------------------------------------------------------------
// Requests load at one per cycle; each is clamped to the top cylinder
// (disk_size - 1) and written to the request memory, and requests past
// MAX_REQUESTS are dropped and reported through batch_overflow. The item with
// last_request set also supplies start_head and starts the run; from then on
// req_stall stays high until the final result is handed to the output
// register. A start head below half the disk sweeps up through the requests
// at or above it, goes to the top cylinder, then serves the rest descending;
// otherwise it sweeps down, goes to cylinder 0, then serves the rest
// ascending. Each move gives one result with its seek distance and the
// running total, and last_move flags the final one. Every result comes from a
// full pass of the request memory through a single compare unit (one read per
// cycle, registered read data), and each pick waits while the output register
// holds a stalled result. Write disk_size only between runs; the top cylinder
// is read live while a run is in progress.
// ---------------------------------------------------------------------------
module scan_disk_scheduler #(
	parameter int unsigned MAX_REQUESTS = sds_pkg::MAX_REQUESTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// disk size register
	input  logic                        cfg_write_en,
	input  logic [sds_pkg::SIZE_W-1:0]  cfg_write_data,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [sds_pkg::CYL_W-1:0]   request_cylinder,
	input  logic [sds_pkg::CYL_W-1:0]   start_head,
	input  logic                        last_request,
	// result channel
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [sds_pkg::CYL_W-1:0]   served_cylinder,
	output logic [sds_pkg::CYL_W-1:0]   seek_distance,
	output logic [sds_pkg::TOTAL_W-1:0] total_movement,
	output logic                        edge_move,
	output logic                        batch_overflow,
	output logic                        last_move
);
	import sds_pkg::*;

	localparam int unsigned IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);

	// configuration
	logic [SIZE_W-1:0] disk_size_q;
	logic [SIZE_W-1:0] size_clamped;
	logic [SIZE_W-1:0] top_full;
	logic [SIZE_W-1:0] half_size;
	logic [CYL_W-1:0]  top_cyl;

	// sequencer and batch state
	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  remaining_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              phase_b_q;
	logic              dir_up_q;
	logic [MAX_REQUESTS-1:0] served_q;
	logic [CYL_W-1:0]  start_q;
	logic [CYL_W-1:0]  head_q;
	logic [TOTAL_W-1:0] total_q;

	// scan pipeline: read issued, data back in the next cycle
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;

	// result register
	logic              res_valid_q;
	logic [CYL_W-1:0]  served_cyl_q;
	logic [CYL_W-1:0]  seek_dist_q;
	logic [TOTAL_W-1:0] total_out_q;
	logic              edge_q;
	logic              ovf_out_q;
	logic              last_q;

	logic              accept;
	logic              has_room;
	logic [CYL_W-1:0]  req_sat;
	logic [CYL_W-1:0]  start_sat;
	logic [CNT_W-1:0]  count_load;
	logic              issue;
	logic              scan_done;
	logic              slot_free;
	logic              pick;
	logic [CYL_W-1:0]  rd_data;
	scan_ctl_t         scan_ctl;
	logic              found;
	logic [CYL_W-1:0]  best;
	logic [IDX_W-1:0]  best_idx;
	logic [CYL_W-1:0]  target;
	logic [CYL_W-1:0]  move_dist;
	logic [TOTAL_W-1:0] total_next;
	logic [CNT_W-1:0]  rem_after;
	logic              is_last;

	// ------------------------------------------------------------------
	// disk geometry: clamp size to [2, 2^16], top cylinder is size - 1
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_size_q <= DISK_SIZE_RESET;
		end else if (cfg_write_en) begin
			disk_size_q <= cfg_write_data;
		end
	end

	always_comb begin
		if (disk_size_q < SIZE_MIN) begin
			size_clamped = SIZE_MIN;
		end else if (disk_size_q > SIZE_MAX) begin
			size_clamped = SIZE_MAX;
		end else begin
			size_clamped = disk_size_q;
		end
	end

	assign top_full  = size_clamped - SIZE_W'(1);
	assign top_cyl   = top_full[CYL_W-1:0];
	assign half_size = size_clamped >> 1;

	// out-of-range cylinders saturate to the top cylinder
	assign req_sat   = (request_cylinder > top_cyl) ? top_cyl : request_cylinder;
	assign start_sat = (start_head > top_cyl) ? top_cyl : start_head;

	// ------------------------------------------------------------------
	// load side: one request per transfer while idle
	// ------------------------------------------------------------------
	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign has_room   = (count_q < CNT_W'(MAX_REQUESTS));
	assign count_load = count_q + CNT_W'(has_room);

	// ------------------------------------------------------------------
	// scan: walk the memory once per result
	// ------------------------------------------------------------------
	assign issue     = (state_q == S_SCAN) && (rd_cnt_q < count_q);
	assign scan_done = (state_q == S_SCAN) && !issue && !valid_s1;

	sds_store #(
		.DEPTH(MAX_REQUESTS)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && has_room),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (req_sat),
		.rd_en   (issue),
		.rd_addr (rd_cnt_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		scan_ctl.clear   = (accept && last_request) || (pick && !is_last);
		scan_ctl.sample  = valid_s1;
		scan_ctl.served  = served_q[idx_s1];
		scan_ctl.phase_b = phase_b_q;
		scan_ctl.dir_up  = dir_up_q;
	end

	sds_scan #(
		.DEPTH(MAX_REQUESTS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (idx_s1),
		.data     (rd_data),
		.start    (start_q),
		.found    (found),
		.best     (best),
		.best_idx (best_idx)
	);

	// ------------------------------------------------------------------
	// pick: serve the best request, or go to the disk end when none is left
	// ------------------------------------------------------------------
	assign slot_free = !res_valid_q || !res_stall;
	assign pick      = (state_q == S_PICK) && slot_free;

	always_comb begin
		if (found) begin
			target = best;
		end else if (dir_up_q) begin
			target = top_cyl;
		end else begin
			target = '0;
		end
	end

	assign move_dist  = (target > head_q) ? (target - head_q) : (head_q - target);
	assign total_next = total_q + TOTAL_W'(move_dist);
	assign rem_after  = found ? (remaining_q - CNT_W'(1)) : remaining_q;
	// the edge move closes the run when the first sweep took everything
	assign is_last    = found ? (phase_b_q && (rem_after == '0))
	                          : (phase_b_q || (remaining_q == '0));

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			remaining_q <= '0;
			rd_cnt_q    <= '0;
			phase_b_q   <= 1'b0;
			dir_up_q    <= 1'b0;
			served_q    <= '0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_load;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_request) begin
							state_q     <= S_SCAN;
							remaining_q <= count_load;
							rd_cnt_q    <= '0;
							phase_b_q   <= 1'b0;
							dir_up_q    <= ({1'b0, start_sat} < half_size);
							served_q    <= '0;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (scan_done) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (pick) begin
						if (found) begin
							served_q[best_idx] <= 1'b1;
							remaining_q        <= rem_after;
						end else begin
							phase_b_q <= 1'b1;
						end
						if (is_last) begin
							state_q <= S_IDLE;
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else begin
							state_q  <= S_SCAN;
							rd_cnt_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// head position, running total and scan index carry no reset
	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (accept && last_request) begin
			start_q <= start_sat;
			head_q  <= start_sat;
			total_q <= '0;
		end else if (pick) begin
			head_q  <= target;
			total_q <= total_next;
		end
	end

	// ------------------------------------------------------------------
	// result register: holds a move until its transfer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pick) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pick) begin
			served_cyl_q <= target;
			seek_dist_q  <= move_dist;
			total_out_q  <= total_next;
			edge_q       <= !found;
			ovf_out_q    <= ovf_q;
			last_q       <= is_last;
		end
	end

	assign res_valid       = res_valid_q;
	assign served_cylinder = served_cyl_q;
	assign seek_distance   = seek_dist_q;
	assign total_movement  = total_out_q;
	assign edge_move       = edge_q;
	assign batch_overflow  = ovf_out_q;
	assign last_move       = last_q;

endmodule

// File: rtl/sds_checker.sv
// ---------------------------------------------------------------------------
// sds_checker
// port-level checks of the scan disk scheduler, bound to the top level
// ---------------------------------------------------------------------------
`include "scan_disk_scheduler_macros.svh"

module sds_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic                        last_request,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic [sds_pkg::CYL_W-1:0]   served_cylinder,
	input logic [sds_pkg::CYL_W-1:0]   seek_distance,
	input logic [sds_pkg::TOTAL_W-1:0] total_movement,
	input logic                        edge_move,
	input logic                        batch_overflow,
	input logic                        last_move
);

	// running total includes the current move
	`SDS_ASSERT_SAME(a_total_covers_seek, res_valid, total_movement >= seek_distance)

	// a last request starts a run, so loading stops
	`SDS_ASSERT_NEXT(a_run_blocks_load, req_valid && !req_stall && last_request, req_stall)

	// mid-run transfer: the run is still going, so no request is taken
	`SDS_ASSERT_SAME(a_mid_run_busy, res_valid && !res_stall && !last_move, req_stall)

	// a stalled result holds
	`SDS_ASSERT_NEXT(a_result_holds, res_valid && res_stall, res_valid && $stable(served_cylinder) && $stable(seek_distance) && $stable(total_movement) && $stable(edge_move) && $stable(batch_overflow) && $stable(last_move))

endmodule

bind scan_disk_scheduler sds_checker u_sds_checker (.*);

// File: tb/sv/scan_disk_scheduler_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// scan_disk_scheduler_tb
// Self-checking bench for the elevator disk scheduler. Request batches go in
// through the valid/stall request channel. A behavioral copy of the sweep
// order predicts every head move, and each move transfer on the result
// channel is checked against the oldest prediction. A short table of corner
// batches comes first, then random batches under several idle/stall mixes,
// with disk size rewrites between batches and one long output hold.
// ---------------------------------------------------------------------------
module scan_disk_scheduler_tb;
	import sds_pkg::*;

	localparam int MAX_REQ      = MAX_REQUESTS_DEF;
	localparam int QUIET_LIMIT  = 20000;  // cycles without any transfer
	localparam int HOLD_CYCLES  = 1500;   // long output hold-off
	localparam int SETTLE       = 8;      // idle cycles before a size write
	localparam int DRAIN        = 64;     // cycles watched after the last move
	localparam int REPORT_MAX   = 10;

	// one head move as seen on the result channel
	typedef struct packed {
		logic [CYL_W-1:0]   cyl;
		logic [CYL_W-1:0]   seek;
		logic [TOTAL_W-1:0] total;
		logic               edge_mv;
		logic               ovf;
		logic               fin;
	} move_t;

	// one row of the corner-case table
	typedef struct packed {
		logic              do_cfg;
		logic [SIZE_W-1:0] cfg;
		logic [CYL_W-1:0]  cyl;
		logic [CYL_W-1:0]  head;
		logic              last;
		logic [1:0]        n_typed;
		move_t             r0;
		move_t             r1;
	} row_t;

	logic                clk;
	logic                arst_n           = 1'b0;
	logic                cfg_write_en     = 1'b0;
	logic [SIZE_W-1:0]   cfg_write_data   = '0;
	logic                req_valid        = 1'b0;
	logic                req_stall;
	logic [CYL_W-1:0]    request_cylinder = '0;
	logic [CYL_W-1:0]    start_head       = '0;
	logic                last_request     = 1'b0;
	logic                res_valid;
	logic                res_stall        = 1'b0;
	logic [CYL_W-1:0]    served_cylinder;
	logic [CYL_W-1:0]    seek_distance;
	logic [TOTAL_W-1:0]  total_movement;
	logic                edge_move;
	logic                batch_overflow;
	logic                last_move;

	// idle / stall mix of the current phase, in percent
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit pressure_go   = 1'b0;
	bit hold_off      = 1'b0;

	// typed expectation riding along with the item on the bus
	logic [1:0] cur_typed_n = '0;
	move_t      cur_t0      = '0;
	move_t      cur_t1      = '0;

	// mirror of the scheduler state
	logic [CYL_W-1:0]  req_mem [MAX_REQ];
	int                req_cnt  = 0;
	logic              ovf_seen = 1'b0;
	logic [SIZE_W-1:0] size_reg = DISK_SIZE_RESET;

	move_t sweep_moves[$];    // moves of the run just started
	move_t pending_moves[$];  // moves still to come out of the block
	row_t  rows[$];

	int fault_count   = 0;
	int req_transfers = 0;
	int res_transfers = 0;
	int batches       = 0;
	int overflow_runs = 0;
	int size_writes   = 0;
	int quiet         = 0;

	scan_disk_scheduler DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_write_data   (cfg_write_data),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.request_cylinder (request_cylinder),
		.start_head       (start_head),
		.last_request     (last_request),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.served_cylinder  (served_cylinder),
		.seek_distance    (seek_distance),
		.total_movement   (total_movement),
		.edge_move        (edge_move),
		.batch_overflow   (batch_overflow),
		.last_move        (last_move)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// sweep predictor
	// ------------------------------------------------------------------

	// top cylinder after clamping the size into 2 .. 2^16
	function automatic logic [CYL_W-1:0] top_of(input logic [SIZE_W-1:0] sz);
		logic [SIZE_W-1:0] e;
		e = (sz < SIZE_MIN) ? SIZE_MIN : ((sz > SIZE_MAX) ? SIZE_MAX : sz);
		return CYL_W'(e - SIZE_W'(1));
	endfunction

	function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] c,
			input logic [CYL_W-1:0] top);
		return (c > top) ? top : c;
	endfunction

	// one head move: distance, running total, and onto the run list
	function automatic void log_move(inout logic [CYL_W-1:0] head,
			input logic [CYL_W-1:0] tgt, inout logic [TOTAL_W-1:0] total,
			input logic edge_mv);
		move_t m;
		logic [CYL_W-1:0] d;
		d = (tgt > head) ? tgt - head : head - tgt;
		total = total + TOTAL_W'(d);
		head = tgt;
		m.cyl = tgt;
		m.seek = d;
		m.total = total;
		m.edge_mv = edge_mv;
		m.ovf = ovf_seen;
		m.fin = 1'b0;
		sweep_moves.push_back(m);
	endfunction

	// store one request; on the last one work out the full elevator sweep
	function automatic void schedule_sweep(input logic [CYL_W-1:0] cyl,
			input logic [CYL_W-1:0] head_in, input logic last);
		logic [CYL_W-1:0]   sorted [MAX_REQ];
		logic [CYL_W-1:0]   top, start, head, v;
		logic [TOTAL_W-1:0] total;
		move_t              m;
		int                 n, i, j;
		top = top_of(size_reg);
		sweep_moves.delete();
		if (req_cnt < MAX_REQ) begin
			req_mem[req_cnt] = clamp_cyl(cyl, top);
			req_cnt++;
		end else begin
			ovf_seen = 1'b1;
		end
		if (!last)
			return;
		batches++;
		if (ovf_seen)
			overflow_runs++;
		n = req_cnt;
		for (i = 0; i < n; i++)
			sorted[i] = req_mem[i];
		// ascending insertion sort
		for (i = 1; i < n; i++) begin
			v = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		start = clamp_cyl(head_in, top);
		head = start;
		total = '0;
		if ({1'b0, start} < (({1'b0, top}) + 17'd1) >> 1) begin
			// head in the lower half: sweep up, hit the top, come back down
			for (i = 0; i < n; i++)
				if (sorted[i] >= start)
					log_move(head, sorted[i], total, 1'b0);
			log_move(head, top, total, 1'b1);
			for (i = n - 1; i >= 0; i--)
				if (sorted[i] < start)
					log_move(head, sorted[i], total, 1'b0);
		end else begin
			// upper half: sweep down, hit cylinder 0, come back up
			for (i = n - 1; i >= 0; i--)
				if (sorted[i] <= start)
					log_move(head, sorted[i], total, 1'b0);
			log_move(head, '0, total, 1'b1);
			for (i = 0; i < n; i++)
				if (sorted[i] > start)
					log_move(head, sorted[i], total, 1'b0);
		end
		m = sweep_moves.pop_back();
		m.fin = 1'b1;
		sweep_moves.push_back(m);
		req_cnt = 0;
		ovf_seen = 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// monitor: size writes, request and move transfers, watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		move_t got, want;
		bit    moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_write_en) begin
				size_reg = cfg_write_data;
				size_writes++;
			end
			// request transfer: advance the mirror, queue what the run will emit
			if (req_valid && !req_stall) begin
				moved = 1'b1;
				req_transfers++;
				schedule_sweep(request_cylinder, start_head, last_request);
				if (last_request && cur_typed_n != 0) begin
					pending_moves.push_back(cur_t0);
					if (cur_typed_n > 1)
						pending_moves.push_back(cur_t1);
				end else begin
					foreach (sweep_moves[i])
						pending_moves.push_back(sweep_moves[i]);
				end
			end
			// move transfer: compare with the oldest prediction
			if (res_valid && !res_stall) begin
				moved = 1'b1;
				res_transfers++;
				got = {served_cylinder, seek_distance, total_movement,
					edge_move, batch_overflow, last_move};
				if (pending_moves.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("%0t: unexpected move: cyl %0d dist %0d total %0d",
							$realtime, got.cyl, got.seek, got.total);
				end else begin
					want = pending_moves.pop_front();
					if (got !== want) begin
						fault_count++;
						if (fault_count <= REPORT_MAX) begin
							$display("%0t: move %0d wrong", $realtime, res_transfers);
							$display("  exp cyl %0d dist %0d total %0d edge %0b ovf %0b last %0b",
								want.cyl, want.seek, want.total, want.edge_mv,
								want.ovf, want.fin);
							$display("  got cyl %0d dist %0d total %0d edge %0b ovf %0b last %0b",
								got.cyl, got.seek, got.total, got.edge_mv,
								got.ovf, got.fin);
						end
					end
				end
			end
		end
		quiet = moved ? 0 : quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer, %0d moves outstanding",
				quiet, pending_moves.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// result side: random stall, forced high during the hold-off
	// ------------------------------------------------------------------
	always @(negedge clk)
		res_stall <= hold_off | ($urandom_range(0, 99) < stall_pct);

	// long hold-off counted here so the sender keeps offering items meanwhile
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// offer one request, idling first at the phase rate; returns after the transfer
	task automatic offer_request(input logic [CYL_W-1:0] cyl,
			input logic [CYL_W-1:0] head, input logic last,
			input logic [1:0] typed_n, input move_t t0, input move_t t1);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			request_cylinder <= CYL_W'($urandom);
			start_head <= CYL_W'($urandom);
			last_request <= 1'($urandom);
			@(negedge clk);
		end
		req_valid <= 1'b1;
		request_cylinder <= cyl;
		start_head <= head;
		last_request <= last;
		cur_typed_n = typed_n;
		cur_t0 = t0;
		cur_t1 = t1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// drop valid, let every predicted move drain, then a few quiet cycles
	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_moves.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// called at a falling edge with the block idle
	task automatic write_size(input logic [SIZE_W-1:0] sz);
		cfg_write_en <= 1'b1;
		cfg_write_data <= sz;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	function automatic move_t mv(input int c, input int d, input int t,
			input bit e, input bit o, input bit f);
		move_t m;
		m.cyl = c[CYL_W-1:0];
		m.seek = d[CYL_W-1:0];
		m.total = t[TOTAL_W-1:0];
		m.edge_mv = e;
		m.ovf = o;
		m.fin = f;
		return m;
	endfunction

	function automatic row_t dir_row(input bit do_cfg, input int cfg,
			input int cyl, input int head, input bit last,
			input int n_typed, input move_t r0, input move_t r1);
		row_t r;
		r.do_cfg = do_cfg;
		r.cfg = cfg[SIZE_W-1:0];
		r.cyl = cyl[CYL_W-1:0];
		r.head = head[CYL_W-1:0];
		r.last = last;
		r.n_typed = n_typed[1:0];
		r.r0 = r0;
		r.r1 = r1;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int               quota, sent, n, k;
		logic [CYL_W-1:0] top, head, cyl, prev, half;
		logic [SIZE_W-1:0] sz;
		bit               first;

		// corner table: do_cfg, size, cylinder, head, last, typed moves
		// after reset, size 200: lowest request from the lowest head, then the top
		rows.push_back(dir_row(0, 0, 0, 0, 1, 2,
			mv(0, 0, 0, 0, 0, 0), mv(199, 199, 199, 1, 0, 1)));
		// all-ones request and head saturate to 199, sweep goes down
		rows.push_back(dir_row(0, 0, 16'hFFFF, 16'hFFFF, 1, 2,
			mv(199, 0, 0, 0, 0, 0), mv(0, 199, 199, 1, 0, 1)));
		// smallest disk
		rows.push_back(dir_row(1, 2, 1, 0, 1, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 16'h5555, 1, 1, 0, '0, '0));
		// largest disk, requests on both sides of a lower-half head
		rows.push_back(dir_row(1, 65536, 16'hFFFF, 16'h1234, 0, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 0, 16'hFFFF, 0, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 16'h8000, 0, 0, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 16'h5555, 16'hAAAA, 0, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 16'hAAAA, 16'h7FFF, 1, 0, '0, '0));
		// repeated requests, zero-length seeks
		rows.push_back(dir_row(0, 0, 100, 16'h5555, 0, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 100, 0, 0, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 100, 16'hAAAA, 1, 0, '0, '0));
		// size below the legal range acts as the minimum
		rows.push_back(dir_row(1, 0, 16'hFFFF, 16'hFFFF, 1, 0, '0, '0));
		// all-ones size acts as the maximum; head exactly at half goes down
		rows.push_back(dir_row(1, 131071, 16'h5555, 16'h5555, 0, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 16'hAAAA, 16'h8000, 1, 0, '0, '0));
		rows.push_back(dir_row(1, 1, 0, 0, 1, 0, '0, '0));
		// request on the top cylinder: edge move of length zero
		rows.push_back(dir_row(1, 1000, 999, 0, 1, 0, '0, '0));
		// one below half goes up, half goes down
		rows.push_back(dir_row(0, 0, 10, 499, 1, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 500, 500, 1, 0, '0, '0));
		rows.push_back(dir_row(0, 0, 1000, 2000, 1, 0, '0, '0));
		rows.push_back(dir_row(1, 200, 16'h00FF, 16'hFF00, 1, 0, '0, '0));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed part, no idling
		foreach (rows[i]) begin
			if (rows[i].do_cfg) begin
				wait_idle();
				write_size(rows[i].cfg);
			end
			offer_request(rows[i].cyl, rows[i].head, rows[i].last,
				rows[i].n_typed, rows[i].r0, rows[i].r1);
		end

		// random part, four idle/stall mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  quota = 80; end
				1: begin send_idle_pct = 84; stall_pct = 0;  quota = 70; end
				2: begin send_idle_pct = 0;  stall_pct = 84; quota = 70; end
				default: begin send_idle_pct = 20; stall_pct = 20; quota = 80; end
			endcase
			sent = 0;
			first = 1'b1;
			while (sent < quota) begin
				// new disk size between runs, always at the start of a phase
				if (first || $urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 5))
						0: sz = SIZE_W'($urandom_range(2, 16));
						1: sz = SIZE_W'($urandom_range(17, 1000));
						2: sz = SIZE_W'($urandom_range(1001, 65536));
						3: begin
							case ($urandom_range(0, 5))
								0: sz = 17'd0;
								1: sz = 17'd1;
								2: sz = 17'd2;
								3: sz = 17'd65535;
								4: sz = 17'd65536;
								default: sz = 17'h1FFFF;
							endcase
						end
						default: sz = SIZE_W'($urandom_range(2, 65536));
					endcase
					wait_idle();
					write_size(sz);
				end
				// batch length: mostly short, now and then past the store size
				if (ph == 2 && first) begin
					pressure_go = 1'b1;
					n = MAX_REQ + 3;
				end else if ($urandom_range(0, 7) == 0) begin
					n = $urandom_range(MAX_REQ - 2, MAX_REQ + 4);
				end else begin
					n = $urandom_range(1, 8);
				end
				first = 1'b0;
				top = top_of(size_reg);
				half = CYL_W'((({1'b0, top}) + 17'd1) >> 1);
				case ($urandom_range(0, 3))
					0: head = CYL_W'($urandom);
					1: head = CYL_W'($urandom_range(0, top));
					2: head = half - CYL_W'($urandom_range(0, 1));
					default: head = $urandom_range(0, 1) ? top : '0;
				endcase
				prev = '0;
				for (k = 0; k < n; k++) begin
					case ($urandom_range(0, 4))
						0: cyl = CYL_W'($urandom);
						1, 2: cyl = CYL_W'($urandom_range(0, top));
						3: cyl = prev;
						default: cyl = $urandom_range(0, 1) ? top : head;
					endcase
					prev = cyl;
					offer_request(cyl, (k == n - 1) ? head : CYL_W'($urandom),
						k == n - 1, 2'd0, '0, '0);
					sent++;
				end
			end
		end

		// drain, then watch a little longer for stray moves
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_moves.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("%0d request transfers in %0d batches (%0d of them overflowed), %0d moves",
			req_transfers, batches, overflow_runs, res_transfers);
		$display("%0d disk size writes incl. clamped extremes, four idle mixes, one long hold",
			size_writes);
		if (pending_moves.size() != 0)
			$display("%0d predicted moves never came out", pending_moves.size());
		if (fault_count == 0 && pending_moves.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
